### rtl/core/fctc_pkg.sv
// Package for the frame checksum trailer check core.
// Holds the result word type, key character codes and matcher state codes.
// No dependencies.
`default_nettype none

package fctc_pkg;

  localparam logic [7:0] CHAR_BAR = 8'h7C;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_C   = 8'h43;
  localparam logic [7:0] CHAR_EQ  = 8'h3D;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;

  localparam int HEADER_BITS = 32;

  typedef enum logic [3:0] {
    MATCH_NONE = 4'b0001,
    MATCH_BAR  = 4'b0010,
    MATCH_A    = 4'b0100,
    MATCH_AC   = 4'b1000
  } match_t;

  typedef struct packed {
    logic                   checksum_ok;
    logic                   key_found;
    logic                   value_error;
    logic [HEADER_BITS-1:0] header_value;
    logic [7:0]             computed_sum;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/fctc_ifs.sv
// Stream interfaces for the frame checksum trailer check core.
// Message byte channel and result channel, each with valid/ready.
// No dependencies.
`default_nettype none

interface fctc_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fctc_res_if;
  logic        valid;
  logic        ready;
  logic        checksum_ok;
  logic        key_found;
  logic        value_error;
  logic [31:0] header_value;
  logic [7:0]  computed_sum;

  modport source (output valid, output checksum_ok, output key_found, output value_error,
                  output header_value, output computed_sum, input ready);
  modport sink   (input valid, input checksum_ok, input key_found, input value_error,
                  input header_value, input computed_sum, output ready);
endinterface

`default_nettype wire

### rtl/core/fctc_parse.sv
// Per-message parse state: running sum, key matcher and decimal value accumulator.
// Produces the result word for the byte in flight. Depends on fctc_pkg.
`default_nettype none

module fctc_parse #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output fctc_pkg::res_t     res
);
  import fctc_pkg::*;

  localparam int WB = VALUE_BITS + 4;
  localparam int XB = VALUE_BITS + HEADER_BITS;

  logic [7:0]            running_sum, running_sum_next;
  logic [7:0]            sum_before_bar, sum_before_bar_next;
  logic [7:0]            saved_sum, saved_sum_next;
  match_t                match_stage, match_stage_next;
  logic                  key_seen, key_seen_next;
  logic                  in_value, in_value_next;
  logic                  value_stopped, value_stopped_next;
  logic                  digit_seen, digit_seen_next;
  logic [VALUE_BITS-1:0] value_acc, value_acc_next;

  logic                  is_digit;
  logic                  key_done;
  logic [WB-1:0]         acc_wide;
  logic [WB-1:0]         prod;
  logic [XB-1:0]         acc_ext;

  assign is_digit = (data_byte >= CHAR_0) && (data_byte <= CHAR_9);
  assign acc_wide = {4'b0, value_acc};
  assign prod     = (acc_wide << 3) + (acc_wide << 1) + WB'(data_byte[3:0]);

  always_comb begin
    running_sum_next    = running_sum + data_byte;
    sum_before_bar_next = sum_before_bar;
    saved_sum_next      = saved_sum;
    match_stage_next    = MATCH_NONE;
    key_seen_next       = key_seen;
    in_value_next       = in_value;
    value_stopped_next  = value_stopped;
    digit_seen_next     = digit_seen;
    value_acc_next      = value_acc;
    key_done            = 1'b0;

    if (in_value && !value_stopped) begin
      if (is_digit) begin
        if (prod[WB-1:VALUE_BITS] != '0) begin
          value_acc_next = '1;
        end else begin
          value_acc_next = prod[VALUE_BITS-1:0];
        end
        digit_seen_next = 1'b1;
      end else begin
        value_stopped_next = 1'b1;
      end
    end

    if (match_stage == MATCH_AC && data_byte == CHAR_EQ) begin
      key_done = 1'b1;
    end else if (data_byte == CHAR_BAR) begin
      sum_before_bar_next = running_sum;
      match_stage_next    = MATCH_BAR;
    end else if (match_stage == MATCH_BAR && data_byte == CHAR_A) begin
      match_stage_next = MATCH_A;
    end else if (match_stage == MATCH_A && data_byte == CHAR_C) begin
      match_stage_next = MATCH_AC;
    end

    if (key_done) begin
      saved_sum_next     = sum_before_bar;
      key_seen_next      = 1'b1;
      in_value_next      = 1'b1;
      value_stopped_next = 1'b0;
      digit_seen_next    = 1'b0;
      value_acc_next     = '0;
    end
  end

  assign acc_ext = XB'(value_acc_next);

  always_comb begin
    res = '0;
    if (key_seen_next) begin
      res.key_found    = 1'b1;
      res.computed_sum = saved_sum_next;
      if (!digit_seen_next) begin
        res.value_error = 1'b1;
      end else begin
        res.header_value = (acc_ext[XB-1:HEADER_BITS] != '0) ? '1 : acc_ext[HEADER_BITS-1:0];
        res.checksum_ok  = (value_acc_next == VALUE_BITS'(saved_sum_next));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      running_sum    <= '0;
      sum_before_bar <= '0;
      saved_sum      <= '0;
      match_stage    <= MATCH_NONE;
      key_seen       <= 1'b0;
      in_value       <= 1'b0;
      value_stopped  <= 1'b0;
      digit_seen     <= 1'b0;
      value_acc      <= '0;
    end else if (step) begin
      running_sum    <= running_sum_next;
      sum_before_bar <= sum_before_bar_next;
      saved_sum      <= saved_sum_next;
      match_stage    <= match_stage_next;
      key_seen       <= key_seen_next;
      in_value       <= in_value_next;
      value_stopped  <= value_stopped_next;
      digit_seen     <= digit_seen_next;
      value_acc      <= value_acc_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/frame_checksum_trailer_check_core.sv
// Frame checksum trailer check core: input word register, parse stage, result register.
// Result: loaded into the result register when the final byte leaves the input word register.
// Throughput: one byte per cycle; only a final byte is held while a result waits.
// Reset: synchronous rst clears all parse state and both valid flags.
// Depends on fctc_pkg, fctc_ifs (fctc_msg_if, fctc_res_if) and fctc_parse.
`default_nettype none

module frame_checksum_trailer_check_core #(
  parameter int VALUE_BITS = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  fctc_msg_if.sink   msg,
  fctc_res_if.source res
);
  import fctc_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  res_t       out_word;
  res_t       parse_res;
  logic       stall;
  logic       advance;

  assign stall     = out_valid && !res.ready;
  assign advance   = in_valid && (!in_last || !stall);
  assign msg.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg.ready) begin
      in_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready) begin
      in_byte <= msg.data_byte;
      in_last <= msg.last_byte;
    end
  end

  fctc_parse #(
    .VALUE_BITS(VALUE_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .res       (parse_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_word <= parse_res;
    end
  end

  assign res.valid        = out_valid;
  assign res.checksum_ok  = out_word.checksum_ok;
  assign res.key_found    = out_word.key_found;
  assign res.value_error  = out_word.value_error;
  assign res.header_value = out_word.header_value;
  assign res.computed_sum = out_word.computed_sum;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for frame_checksum_trailer_check_core: streams messages byte by byte,
// predicts each end-of-message result and compares every field of the result words.
// Depends on fctc_pkg, fctc_ifs and the core RTL.
`default_nettype none

module testbench;
  import fctc_pkg::*;

  localparam int VALUE_BITS     = 32;
  localparam int PHASE_WORDS    = 450;
  localparam int SETTLE_CYCLES  = 10;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] KEY_CHARS [4] = '{CHAR_BAR, CHAR_A, CHAR_C, CHAR_EQ};

  typedef struct packed {
    logic [7:0]  run_sum;
    logic [7:0]  bar_sum;
    logic [7:0]  key_sum;
    match_t      stage;
    logic        key_seen;
    logic        in_val;
    logic        val_stopped;
    logic        got_digit;
    logic [63:0] acc;
  } parse_state_t;

  typedef struct {
    string text;
    bit    typed;
    res_t  want;
  } frame_row_t;

  logic clk;
  logic rst;

  fctc_msg_if msg_ch ();
  fctc_res_if res_ch ();

  frame_checksum_trailer_check_core #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .msg(msg_ch),
    .res(res_ch)
  );

  parse_state_t parse_st;
  res_t         expected_q [$];
  logic [7:0]   frame_q [$];
  int           send_idle_pct;
  int           recv_stall_pct;
  int           words_sent;
  int           frames_sent;
  int           results_checked;
  int           errors;

  frame_row_t directed_rows [7] = '{
    '{"A",              1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 8'd0}},
    '{"|AC=",           1'b1, '{1'b0, 1'b1, 1'b1, 32'd0, 8'd0}},
    '{"x|AC=120",       1'b1, '{1'b1, 1'b1, 1'b0, 32'd120, 8'd120}},
    '{"|AC=4294967296", 1'b1, '{1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 8'd0}},
    '{"|AC=-",          1'b1, '{1'b0, 1'b1, 1'b1, 32'd0, 8'd0}},
    '{"|AC=7x",         1'b0, '0},
    '{"|AC=1|AC=2",     1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void clear_parse();
    parse_st       = '0;
    parse_st.stage = MATCH_NONE;
  endfunction

  // advance the parse by one byte; returns the end-of-message result on the final byte
  function automatic res_t parse_word(input logic [7:0] b, input logic is_last);
    logic [63:0] d;
    logic [63:0] vmax;
    logic        key_done;
    res_t        r;
    vmax     = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_BITS);
    key_done = 1'b0;
    r        = '0;
    if (parse_st.in_val && !parse_st.val_stopped) begin
      if (b >= CHAR_0 && b <= CHAR_9) begin
        d = 64'(b - CHAR_0);
        if (parse_st.acc > (vmax - d) / 10) parse_st.acc = vmax;
        else parse_st.acc = parse_st.acc * 10 + d;
        parse_st.got_digit = 1'b1;
      end else begin
        parse_st.val_stopped = 1'b1;
      end
    end
    if (parse_st.stage == MATCH_AC && b == CHAR_EQ) begin
      key_done       = 1'b1;
      parse_st.stage = MATCH_NONE;
    end else if (b == CHAR_BAR) begin
      parse_st.bar_sum = parse_st.run_sum;
      parse_st.stage   = MATCH_BAR;
    end else if (parse_st.stage == MATCH_BAR && b == CHAR_A) begin
      parse_st.stage = MATCH_A;
    end else if (parse_st.stage == MATCH_A && b == CHAR_C) begin
      parse_st.stage = MATCH_AC;
    end else begin
      parse_st.stage = MATCH_NONE;
    end
    if (key_done) begin
      parse_st.key_sum     = parse_st.bar_sum;
      parse_st.key_seen    = 1'b1;
      parse_st.in_val      = 1'b1;
      parse_st.val_stopped = 1'b0;
      parse_st.got_digit   = 1'b0;
      parse_st.acc         = '0;
    end
    parse_st.run_sum = parse_st.run_sum + b;
    if (is_last) begin
      if (parse_st.key_seen) begin
        r.key_found    = 1'b1;
        r.computed_sum = parse_st.key_sum;
        if (!parse_st.got_digit) begin
          r.value_error = 1'b1;
        end else begin
          r.header_value = (parse_st.acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                          : parse_st.acc[31:0];
          r.checksum_ok  = (parse_st.acc == 64'(parse_st.key_sum));
        end
      end
      clear_parse();
    end
    return r;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic is_last, input bit typed,
                           input res_t want);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.data_byte <= b;
    msg_ch.last_byte <= is_last;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    words_sent++;
    r = parse_word(b, is_last);
    if (is_last) begin
      frames_sent++;
      expected_q.push_back(typed ? want : r);
    end
  endtask

  function automatic void push_digits(input int n);
    repeat (n) frame_q.push_back(CHAR_0 + 8'($urandom_range(9)));
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  // mostly keyed messages with random content, some noise and broken keys
  function automatic void build_random_frame();
    int         n;
    int         skip;
    logic [7:0] b;
    logic [7:0] s;
    frame_q.delete();
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 8);
      repeat (n) frame_q.push_back(8'($urandom_range(255)));
      return;
    end
    s = '0;
    n = $urandom_range(0, 5);
    repeat (n) begin
      if ($urandom_range(9) < 3) b = KEY_CHARS[$urandom_range(3)];
      else b = 8'($urandom_range(255));
      frame_q.push_back(b);
      s = s + b;
    end
    skip = ($urandom_range(9) == 0) ? $urandom_range(3) : 4;
    for (int i = 0; i < 4; i++) begin
      if (i != skip) frame_q.push_back(KEY_CHARS[i]);
    end
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        if ($urandom_range(3) == 0) frame_q.push_back(CHAR_0);
        push_text($sformatf("%0d", s));
      end
      4, 5: push_digits($urandom_range(1, 4));
      6: push_digits($urandom_range(10, 12));
      7: ;
      8: begin
        case ($urandom_range(3))
          0: frame_q.push_back(CHAR_SPACE);
          1: frame_q.push_back(CHAR_PLUS);
          2: frame_q.push_back(CHAR_MINUS);
          default: frame_q.push_back(8'($urandom_range(255)));
        endcase
      end
      default: push_text($sformatf("%0d", 8'(s + 8'd1)));
    endcase
    if ($urandom_range(1) == 1) begin
      n = $urandom_range(0, 3);
      repeat (n) frame_q.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(6) == 0) begin
      foreach (KEY_CHARS[i]) frame_q.push_back(KEY_CHARS[i]);
      push_digits(1);
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result word with no expectation pending");
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (res_ch.checksum_ok !== want.checksum_ok)
          report_mismatch($sformatf("checksum_ok got %0b want %0b",
                                    res_ch.checksum_ok, want.checksum_ok));
        if (res_ch.key_found !== want.key_found)
          report_mismatch($sformatf("key_found got %0b want %0b",
                                    res_ch.key_found, want.key_found));
        if (res_ch.value_error !== want.value_error)
          report_mismatch($sformatf("value_error got %0b want %0b",
                                    res_ch.value_error, want.value_error));
        if (res_ch.header_value !== want.header_value)
          report_mismatch($sformatf("header_value got %0d want %0d",
                                    res_ch.header_value, want.header_value));
        if (res_ch.computed_sum !== want.computed_sum)
          report_mismatch($sformatf("computed_sum got %0d want %0d",
                                    res_ch.computed_sum, want.computed_sum));
      end
    end
  end

  initial begin : stimulus
    int   phase_end;
    int   len;
    clear_parse();
    errors           = 0;
    words_sent       = 0;
    frames_sent      = 0;
    results_checked  = 0;
    send_idle_pct    = 27;
    recv_stall_pct   = 85;
    rst              <= 1'b1;
    msg_ch.valid     <= 1'b0;
    msg_ch.data_byte <= '0;
    msg_ch.last_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      len = directed_rows[r].text.len();
      for (int i = 0; i < len; i++)
        send_word(directed_rows[r].text[i], i == len - 1, directed_rows[r].typed,
                  directed_rows[r].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      // hold off until the result queue drains
      msg_ch.valid <= 1'b0;
      @(posedge clk);
      while (expected_q.size() != 0) @(posedge clk);
      case (phase)
        0: begin send_idle_pct = 27; recv_stall_pct = 85; end
        1: begin send_idle_pct = 85; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        build_random_frame();
        foreach (frame_q[i]) send_word(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
      end
    end

    msg_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d message bytes in %0d messages; %0d end-of-message results compared.",
             words_sent, frames_sent, results_checked);
    $display("Pacing covered slow sender, slow receiver and back-to-back traffic.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
